>>> rtl/assert_macros.svh
// Assertion macros shared by the sample history ring RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// Check that a consequent follows whenever the antecedent holds.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> cons) \
    else $error(msg);

`endif

>>> rtl/shr_pkg.sv
// Package for the sample history ring: sizes, command codes and word types.
package shr_pkg;

  localparam int DEPTH = 64;
  localparam int AddrW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int ValW  = 32;
  localparam int AgeW  = 7;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_MAX   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e            command;
    logic [ValW-1:0] sample;
    logic [AgeW-1:0] age;
  } in_word_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [CntW-1:0] valid_count;
  } out_word_t;

  // Controls for the shared compare unit.
  typedef struct packed {
    logic clr;
    logic upd;
  } max_ctrl_t;

endpackage

>>> rtl/shr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module shr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/shr_max_unit.sv
// Shared compare unit: running maximum over words streamed from the store.
module shr_max_unit (
  input  logic                     clk_i,
  input  shr_pkg::max_ctrl_t       ctrl_i,
  input  logic [shr_pkg::ValW-1:0] data_i,
  output logic [shr_pkg::ValW-1:0] max_o
);

  logic [shr_pkg::ValW-1:0] max_q;
  logic [shr_pkg::ValW-1:0] max_d;

  always_comb begin
    max_d = max_q;
    if (ctrl_i.clr) begin
      max_d = '0;
    end else if (ctrl_i.upd && (data_i > max_q)) begin
      max_d = data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q <= max_d;
  end

  assign max_o = max_q;

endmodule

>>> rtl/sample_history_ring.sv
// Top level of the sample history ring: sequencer, pointers and output register.
// Add, clear, out-of-range read and empty maximum go straight from idle to the result
// state; a hit read passes the read state; other maxima pass the max and drain states
// (one store read per cycle through the single read port and the shared compare unit).
// One command is in flight at a time; the next is taken the cycle after the result loads.
// Reset clears position, count, sequencer and output valid; store contents are not cleared.
`include "assert_macros.svh"

module sample_history_ring (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  shr_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output shr_pkg::out_word_t out_word_o
);

  localparam int AddrW = shr_pkg::AddrW;
  localparam int CntW  = shr_pkg::CntW;
  localparam int ValW  = shr_pkg::ValW;
  localparam int AgeW  = shr_pkg::AgeW;
  localparam int IdxW  = AddrW + 1;
  localparam int CmpW  = (AgeW > CntW) ? AgeW : CntW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAX,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  state_e             state_q, state_d;
  logic [AddrW-1:0]   wp_q, wp_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic [CntW-1:0]    scan_q, scan_d;
  logic [ValW-1:0]    res_val_q, res_val_d;
  logic               res_max_q, res_max_d;
  logic               out_valid_q, out_valid_d;
  shr_pkg::out_word_t out_q, out_d;

  logic               accept;
  logic               out_free;
  logic               age_hit;
  logic [IdxW-1:0]    idx_raw;
  logic [AddrW-1:0]   read_slot;
  logic               ram_we;
  logic [AddrW-1:0]   ram_raddr;
  logic [ValW-1:0]    ram_rdata;
  logic [ValW-1:0]    max_val;
  shr_pkg::max_ctrl_t max_ctrl;

  // Only idle takes a new word; a finished result may still wait in the output register.
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Age hits only inside the valid window.
  assign age_hit = CmpW'(in_word_i.age) < CmpW'(fill_q);

  // Slot of the word 'age' places before the newest, wrapped into the store.
  assign idx_raw   = IdxW'(wp_q) + IdxW'(shr_pkg::DEPTH - 1) - IdxW'(in_word_i.age);
  assign read_slot = (idx_raw >= IdxW'(shr_pkg::DEPTH))
                     ? AddrW'(idx_raw - IdxW'(shr_pkg::DEPTH))
                     : AddrW'(idx_raw);

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    scan_d      = scan_q;
    res_val_d   = res_val_q;
    res_max_d   = res_max_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_raddr   = read_slot;
    max_ctrl    = '0;

    // Drop the output word once taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_max_d = 1'b0;
          case (in_word_i.command)
            shr_pkg::CMD_ADD: begin
              // Write at the position, advance it with wrap, grow count up to full.
              ram_we    = 1'b1;
              wp_d      = (wp_q == AddrW'(shr_pkg::DEPTH - 1)) ? '0 : wp_q + 1'b1;
              fill_d    = (fill_q == CntW'(shr_pkg::DEPTH)) ? fill_q : fill_q + 1'b1;
              res_val_d = in_word_i.sample;
              state_d   = ST_RESULT;
            end
            shr_pkg::CMD_READ: begin
              if (age_hit) begin
                state_d = ST_READ;
              end else begin
                res_val_d = '0;
                state_d   = ST_RESULT;
              end
            end
            shr_pkg::CMD_MAX: begin
              max_ctrl.clr = 1'b1;
              if (fill_q == '0) begin
                res_val_d = '0;
                state_d   = ST_RESULT;
              end else begin
                scan_d  = '0;
                state_d = ST_MAX;
              end
            end
            shr_pkg::CMD_CLEAR: begin
              wp_d      = '0;
              fill_d    = '0;
              res_val_d = '0;
              state_d   = ST_RESULT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_READ: begin
        // Registered read data of the slot addressed at accept.
        res_val_d = ram_rdata;
        state_d   = ST_RESULT;
      end

      ST_MAX: begin
        // While fill < DEPTH the valid words sit in slots 0..fill-1; when full, all are valid.
        ram_raddr    = scan_q[AddrW-1:0];
        max_ctrl.upd = (scan_q != '0);
        scan_d       = scan_q + 1'b1;
        if (scan_q == fill_q - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        // Fold in the last word read.
        max_ctrl.upd = 1'b1;
        res_max_d    = 1'b1;
        state_d      = ST_RESULT;
      end

      ST_RESULT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.value       = res_max_q ? max_val : res_val_q;
          out_d.valid_count = fill_q;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      scan_q      <= '0;
      res_max_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      scan_q      <= scan_d;
      res_max_q   <= res_max_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    res_val_q <= res_val_d;
    out_q     <= out_d;
  end

  shr_ram #(
    .WIDTH (ValW),
    .DEPTH (shr_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_word_i.sample),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  shr_max_unit u_max (
    .clk_i  (clk_i),
    .ctrl_i (max_ctrl),
    .data_i (ram_rdata),
    .max_o  (max_val)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, fill_q <= CntW'(shr_pkg::DEPTH), "fill count above depth")
  `ASSERT_IMPL(a_wp_tracks_fill, clk_i, rst_ni, fill_q != CntW'(shr_pkg::DEPTH), CntW'(wp_q) == fill_q, "write position off fill count before full")
  `ASSERT_IMPL(a_scan_in_window, clk_i, rst_ni, state_q == ST_MAX, scan_q < fill_q, "max scan beyond valid words")
  `ASSERT_IMPL(a_add_echo, clk_i, rst_ni, accept && (in_word_i.command == shr_pkg::CMD_ADD) && !out_valid_o, ##2 (out_valid_o && (out_word_o.value == $past(in_word_i.sample, 2))), "add word not echoed")

endmodule

>>> test/tb_sample_history_ring.sv
// Self-checking testbench for the sample history ring: directed and random command words.
module tb_sample_history_ring;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = shr_pkg::DEPTH;
  localparam int AddrW = shr_pkg::AddrW;
  localparam int CntW  = shr_pkg::CntW;
  localparam int ValW  = shr_pkg::ValW;
  localparam int AgeW  = shr_pkg::AgeW;

  // The slowest word is a maximum over a full history, with the longest sender gap
  // and receiver stall on top. The limit allows several times that worst case for
  // each of the about 620 words.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = DEPTH + 16;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  shr_pkg::in_word_t  in_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  shr_pkg::out_word_t out_word_o;

  // Random idling on both sides; cleared for the last stretch of the run.
  bit idle_on = 1'b1;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Results still owed by the block, oldest first.
  shr_pkg::out_word_t owed_results[$];

  // Own copy of the history: store, next write slot and number of valid samples.
  logic [ValW-1:0]  hist_store [DEPTH];
  logic [AddrW-1:0] hist_wr_pos = '0;
  logic [CntW-1:0]  hist_fill   = '0;

  sample_history_ring DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: end the run as failed once the cycle limit is reached.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_sample_history_ring: FAIL");
    $finish;
  end

  // Store slot of the sample 'back' places behind the newest one.
  function automatic int slot_of_age(int back);
    return (int'(hist_wr_pos) + DEPTH - back - 1) % DEPTH;
  endfunction

  // Apply one command word to the history copy and return the result it gives.
  function automatic shr_pkg::out_word_t apply_history_cmd(shr_pkg::in_word_t w);
    shr_pkg::out_word_t r;
    r = '0;
    case (w.command)
      shr_pkg::CMD_ADD: begin
        hist_store[hist_wr_pos] = w.sample;
        hist_wr_pos = (int'(hist_wr_pos) == DEPTH - 1) ? '0 : hist_wr_pos + 1'b1;
        if (int'(hist_fill) < DEPTH) hist_fill = hist_fill + 1'b1;
        r.value = w.sample;
      end
      shr_pkg::CMD_READ: begin
        if (w.age < hist_fill) r.value = hist_store[slot_of_age(int'(w.age))];
      end
      shr_pkg::CMD_MAX: begin
        for (int k = 0; k < int'(hist_fill); k++) begin
          if (hist_store[slot_of_age(k)] > r.value) r.value = hist_store[slot_of_age(k)];
        end
      end
      default: begin
        hist_wr_pos = '0;
        hist_fill   = '0;
      end
    endcase
    r.valid_count = hist_fill;
    return r;
  endfunction

  function automatic shr_pkg::in_word_t make_word(shr_pkg::cmd_e cmd, logic [ValW-1:0] smp,
                                                  logic [AgeW-1:0] back);
    shr_pkg::in_word_t w;
    w.command = cmd;
    w.sample  = smp;
    w.age     = back;
    return w;
  endfunction

  // Present one word, hold it until accepted, then log the result it owes.
  task automatic send_word(shr_pkg::in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    owed_results.push_back(apply_history_cmd(w));
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Compare one accepted result against the oldest owed one.
  task automatic check_result(shr_pkg::out_word_t got);
    shr_pkg::out_word_t want;
    if (owed_results.size() == 0) begin
      $error("unexpected result: value %h valid_count %0d", got.value, got.valid_count);
      mismatch_count++;
    end else begin
      want = owed_results.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %h, got %h", want.value, got.value);
        mismatch_count++;
      end
      if (got.valid_count !== want.valid_count) begin
        $error("valid_count: expected %0d, got %0d", want.valid_count, got.valid_count);
        mismatch_count++;
      end
    end
  endtask

  // Receiver: take results at each edge, then pick the stall for the next cycle.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_result(out_word_o);
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Sample values lean on the extremes now and then so the maximum sees ties and edges.
  function automatic logic [ValW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return ValW'($urandom_range(0, 255));
      default: return ValW'($urandom);
    endcase
  endfunction

  // Ages mostly hit valid samples; the rest probe the edge and the far range.
  function automatic logic [AgeW-1:0] pick_age();
    int sel;
    sel = $urandom_range(0, 9);
    if (hist_fill != 0 && sel < 6) return AgeW'($urandom_range(0, int'(hist_fill) - 1));
    if (sel == 6) return AgeW'(hist_fill);
    if (sel == 7) return AgeW'($urandom_range(DEPTH, 127));
    return AgeW'($urandom_range(0, 127));
  endfunction

  // Random word: add_pct percent adds, clear_pct percent clears, the rest reads and maxima.
  function automatic shr_pkg::in_word_t random_word(int add_pct, int clear_pct);
    int roll;
    shr_pkg::cmd_e cmd;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) cmd = shr_pkg::CMD_ADD;
    else if (roll < add_pct + clear_pct) cmd = shr_pkg::CMD_CLEAR;
    else if ($urandom_range(0, 2) == 0) cmd = shr_pkg::CMD_MAX;
    else cmd = shr_pkg::CMD_READ;
    return make_word(cmd, pick_sample(), pick_age());
  endfunction

  // Read and maximum on an empty history, and a clear with nothing stored.
  task automatic test_empty_history();
    send_word(make_word(shr_pkg::CMD_READ, '1, '0));
    send_word(make_word(shr_pkg::CMD_READ, '0, '1));
    send_word(make_word(shr_pkg::CMD_MAX, '1, '1));
    send_word(make_word(shr_pkg::CMD_CLEAR, '0, '0));
  endtask

  // Extreme samples, reads from newest to oldest, one past the end and far out.
  task automatic test_add_and_read();
    send_word(make_word(shr_pkg::CMD_ADD, 32'h0000_0000, '1));
    send_word(make_word(shr_pkg::CMD_ADD, 32'hFFFF_FFFF, '0));
    send_word(make_word(shr_pkg::CMD_ADD, 32'h8000_0000, 7'd3));
    send_word(make_word(shr_pkg::CMD_ADD, 32'h7FFF_FFFF, 7'd64));
    send_word(make_word(shr_pkg::CMD_ADD, 32'h0000_0001, 7'd1));
    send_word(make_word(shr_pkg::CMD_READ, 32'hDEAD_BEEF, 7'd0));
    send_word(make_word(shr_pkg::CMD_READ, '0, 7'd1));
    send_word(make_word(shr_pkg::CMD_READ, '0, 7'd4));
    send_word(make_word(shr_pkg::CMD_READ, '1, 7'd5));
    send_word(make_word(shr_pkg::CMD_READ, '0, 7'd64));
    send_word(make_word(shr_pkg::CMD_READ, '0, 7'd127));
    send_word(make_word(shr_pkg::CMD_MAX, 32'h1234_5678, 7'd2));
  endtask

  // Clear drops the history; stale data must not show through.
  task automatic test_clear();
    send_word(make_word(shr_pkg::CMD_CLEAR, '1, '1));
    send_word(make_word(shr_pkg::CMD_READ, '0, 7'd0));
    send_word(make_word(shr_pkg::CMD_MAX, '0, '0));
    send_word(make_word(shr_pkg::CMD_ADD, 32'h1234_5678, 7'd127));
    send_word(make_word(shr_pkg::CMD_READ, '0, 7'd0));
  endtask

  // Add-heavy stream that aims to fill the history and wrap the write slot.
  task automatic test_full_wrap();
    repeat (200) send_word(random_word(75, 1));
  endtask

  // Sender holds off until the block has returned every result.
  task automatic test_drain_pause();
    wait_for_drain();
    send_word(make_word(shr_pkg::CMD_MAX, '0, '0));
    send_word(make_word(shr_pkg::CMD_READ, '0, AgeW'(DEPTH - 1)));
  endtask

  // Balanced mix with occasional clears so the count passes through every level.
  task automatic test_random_mix();
    repeat (250) send_word(random_word(45, 3));
  endtask

  // Back-to-back words with both sides always ready.
  task automatic test_steady_run();
    idle_on = 1'b0;
    repeat (150) send_word(random_word(50, 2));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_history();
    test_add_and_read();
    test_clear();
    test_full_wrap();
    test_drain_pause();
    test_random_mix();
    test_steady_run();

    // Let the last results come back, then give the block time to show a stray one.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("tb_sample_history_ring: PASS");
    end else begin
      $display("tb_sample_history_ring: FAIL");
    end
    $finish;
  end

endmodule
